>>> sv/wsdf_pkg.sv
package wsdf_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [3:0] OPCODE_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING      = 4'd9;
  localparam logic [3:0] OP_PONG      = 4'd10;

  localparam logic [6:0] LEN_MAGIC_16 = 7'd126;
  localparam logic [6:0] LEN_MAGIC_64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_CLOSE   = 2'd1,
    EV_ERROR   = 2'd2,
    EV_EMPTY   = 2'd3
  } wsdf_event_t;

  typedef struct packed {
    wsdf_event_t kind;
    logic [7:0]  payload;
    logic [3:0]  opcode;
    logic        fin;
    logic        last;
    logic [15:0] close_code;
  } wsdf_result_t;

  function automatic logic is_data_op(input logic [3:0] op);
    return op inside {[4'd0:4'd2]};
  endfunction

  function automatic logic is_known_op(input logic [3:0] op);
    return is_data_op(op) || op inside {OPCODE_CLOSE, OP_PING, OP_PONG};
  endfunction

endpackage

>>> sv/wsdf_parser.sv
module wsdf_parser
  import wsdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_en,
  input  logic [7:0]   rx_byte,
  output logic         res_valid,
  output wsdf_result_t res
);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_LENGTH,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD
  } phase_t;

  phase_t      phase_r,  phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r,    fin_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [3:0]  cnt_r,    cnt_nxt;
  logic [31:0] key_r,    key_nxt;
  logic [1:0]  mpos_r,   mpos_nxt;
  logic [15:0] close_r,  close_nxt;
  logic        halted_r, halted_nxt;

  logic        hdr_done;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic        is_last;
  logic [15:0] code;

  always_comb begin
    case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
    if (!masked_r) begin
      key_byte = 8'd0;
    end
  end

  assign plain   = rx_byte ^ key_byte;
  assign is_last = (remain_r == 64'd1);

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    fin_nxt    = fin_r;
    masked_nxt = masked_r;
    remain_nxt = remain_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    mpos_nxt   = mpos_r;
    close_nxt  = close_r;
    halted_nxt = halted_r;
    hdr_done   = 1'b0;
    code       = 16'd0;
    res_valid  = 1'b0;
    res.kind       = EV_PAYLOAD;
    res.payload    = 8'd0;
    res.last       = 1'b0;
    res.close_code = 16'd0;

    if (!halted_r) begin
      case (phase_r)
        PH_OPCODE: begin
          opcode_nxt = rx_byte[3:0];
          fin_nxt    = rx_byte[7];
          if (rx_byte[6:4] != 3'd0 || !is_known_op(rx_byte[3:0])) begin
            halted_nxt = 1'b1;
            res_valid  = 1'b1;
            res.kind   = EV_ERROR;
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          masked_nxt = rx_byte[7];
          key_nxt    = 32'd0;
          remain_nxt = 64'd0;
          if (rx_byte[6:0] == LEN_MAGIC_16) begin
            cnt_nxt   = EXT16_BYTES;
            phase_nxt = PH_EXTLEN;
          end else if (rx_byte[6:0] == LEN_MAGIC_64) begin
            cnt_nxt   = EXT64_BYTES;
            phase_nxt = PH_EXTLEN;
          end else begin
            remain_nxt = {57'd0, rx_byte[6:0]};
            if (rx_byte[7]) begin
              cnt_nxt   = KEY_BYTES;
              phase_nxt = PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          remain_nxt = {remain_r[55:0], rx_byte};
          cnt_nxt    = cnt_r - 4'd1;
          if (cnt_nxt == 4'd0) begin
            if (masked_r) begin
              cnt_nxt   = KEY_BYTES;
              phase_nxt = PH_MASK;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          cnt_nxt = cnt_r - 4'd1;
          if (cnt_nxt == 4'd0) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          mpos_nxt   = mpos_r + 2'd1;
          remain_nxt = remain_r - 64'd1;
          if (is_last) begin
            phase_nxt = PH_OPCODE;
          end
          if (is_data_op(opcode_r)) begin
            res_valid   = 1'b1;
            res.kind    = EV_PAYLOAD;
            res.payload = plain;
            res.last    = is_last;
          end else if (opcode_r == OPCODE_CLOSE) begin
            close_nxt = {close_r[7:0], plain};
            cnt_nxt   = cnt_r + 4'd1;
            if (cnt_nxt >= 4'd2 || is_last) begin
              code = close_nxt;
              if (cnt_nxt == 4'd1) begin
                code = {close_nxt[7:0], 8'd0};
              end
              close_nxt      = code;
              halted_nxt     = 1'b1;
              res_valid      = 1'b1;
              res.kind       = EV_CLOSE;
              res.close_code = code;
            end
          end
        end
        default: begin
          phase_nxt = PH_OPCODE;
        end
      endcase

      if (hdr_done) begin
        mpos_nxt  = 2'd0;
        cnt_nxt   = 4'd0;
        close_nxt = 16'd0;
        if (remain_nxt != 64'd0) begin
          phase_nxt = PH_PAYLOAD;
        end else begin
          phase_nxt = PH_OPCODE;
          if (is_data_op(opcode_r)) begin
            res_valid = 1'b1;
            res.kind  = EV_EMPTY;
            res.last  = 1'b1;
          end else if (opcode_r == OPCODE_CLOSE) begin
            halted_nxt = 1'b1;
            res_valid  = 1'b1;
            res.kind   = EV_CLOSE;
          end
        end
      end
    end

    res.opcode = opcode_nxt;
    res.fin    = fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPCODE;
      opcode_r <= 4'd0;
      fin_r    <= 1'b0;
      masked_r <= 1'b0;
      remain_r <= 64'd0;
      cnt_r    <= 4'd0;
      key_r    <= 32'd0;
      mpos_r   <= 2'd0;
      close_r  <= 16'd0;
      halted_r <= 1'b0;
    end else if (byte_en) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      fin_r    <= fin_nxt;
      masked_r <= masked_nxt;
      remain_r <= remain_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      mpos_r   <= mpos_nxt;
      close_r  <= close_nxt;
      halted_r <= halted_nxt;
    end
  end

  a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !res_valid)
    else $error("result produced while halted");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_en && res_valid && (res.kind == EV_ERROR || res.kind == EV_CLOSE)) |=> halted_r)
    else $error("close or error did not halt parser");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (remain_r != 64'd0))
    else $error("payload phase with zero bytes remaining");

endmodule

>>> sv/websocket_frame_deframer_core.sv
// Byte-wide WebSocket receive deframer. One byte is taken per cycle whenever
// in_tready is high; header bytes are absorbed and each data-frame payload
// byte is unmasked and registered into the output buffer, with out_tlast on
// the last byte of the frame. A two-entry output buffer keeps in_tready high
// while one result waits, so the sustained rate is one byte per cycle; the
// input stalls only when both output entries are full. After a close or an
// error result the block takes and drops all further bytes until reset.
module websocket_frame_deframer_core
  import wsdf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [11:8] frame_opcode,
                                             // [12] frame_final, [28:13] close_code
  output logic                   out_tlast,  // last_of_frame
  output logic [OUT_TUSER_W-1:0] out_tuser   // [1:0] event_kind
);

  logic         accept;
  logic         res_valid;
  wsdf_result_t res;
  logic         push;
  logic         pop;

  logic         out_valid_r;
  wsdf_result_t out_data_r;
  logic         skid_valid_r;
  wsdf_result_t skid_data_r;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && res_valid;
  assign pop       = out_valid_r && out_tready;

  wsdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (accept),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_data_r.close_code, out_data_r.fin,
                       out_data_r.opcode, out_data_r.payload};
  assign out_tlast  = out_data_r.last;
  assign out_tuser  = out_data_r.kind;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result lost while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_tready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved to output");

endmodule

>>> bench/tb_websocket_frame_deframer_core.sv
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_core;
  import wsdf_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_LEN,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]   b;
    logic         typed;
    wsdf_result_t want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // shadow deframer state
  parse_phase_t ph = PH_HDR;
  logic [3:0]   cur_op = '0;
  logic         cur_fin = 1'b0;
  logic         cur_masked = 1'b0;
  logic [63:0]  left = '0;
  logic [3:0]   hdr_left = '0;
  logic [31:0]  key = '0;
  logic [1:0]   key_pos = '0;
  logic [15:0]  status = '0;
  logic         stopped = 1'b0;

  wsdf_result_t pending_events [$];
  row_t         dir_rows [23];
  int           errors = 0;
  int           sent = 0;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;

  websocket_frame_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  initial begin
    #400us;
    $display("status: fail");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= 100) begin
      $display("mismatch %0t: %s got %h want %h", $time, what, got, want);
    end
  endtask

  function automatic wsdf_result_t make_ev(input wsdf_event_t k, input logic [7:0] d,
                                           input logic l, input logic [15:0] c);
    wsdf_result_t r;
    r.kind       = k;
    r.payload    = d;
    r.opcode     = cur_op;
    r.fin        = cur_fin;
    r.last       = l;
    r.close_code = c;
    return r;
  endfunction

  function automatic bit header_end(output wsdf_result_t r);
    r        = '0;
    key_pos  = '0;
    hdr_left = '0;
    status   = '0;
    if (left != 64'd0) begin
      ph = PH_DATA;
      return 1'b0;
    end
    ph = PH_HDR;
    if (cur_op <= 4'd2) begin
      r = make_ev(EV_EMPTY, 8'h00, 1'b1, 16'h0000);
      return 1'b1;
    end
    if (cur_op == OPCODE_CLOSE) begin
      stopped = 1'b1;
      r = make_ev(EV_CLOSE, 8'h00, 1'b0, 16'h0000);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output wsdf_result_t r);
    logic [7:0] kb;
    logic [7:0] d;
    logic       last_b;
    r = '0;
    if (stopped) return 1'b0;
    case (ph)
      PH_HDR: begin
        cur_op  = b[3:0];
        cur_fin = b[7];
        if (b[6:4] != 3'b000 || !(cur_op <= 4'd2 || cur_op == OPCODE_CLOSE ||
                                  cur_op == OP_PING || cur_op == OP_PONG)) begin
          stopped = 1'b1;
          r = make_ev(EV_ERROR, 8'h00, 1'b0, 16'h0000);
          return 1'b1;
        end
        ph = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        cur_masked = b[7];
        key        = '0;
        left       = '0;
        if (b[6:0] == LEN_MAGIC_16) begin
          hdr_left = EXT16_BYTES;
          ph = PH_EXT;
          return 1'b0;
        end
        if (b[6:0] == LEN_MAGIC_64) begin
          hdr_left = EXT64_BYTES;
          ph = PH_EXT;
          return 1'b0;
        end
        left = {57'd0, b[6:0]};
        if (cur_masked) begin
          hdr_left = KEY_BYTES;
          ph = PH_KEY;
          return 1'b0;
        end
        return header_end(r);
      end
      PH_EXT: begin
        left     = {left[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 4'd0) return 1'b0;
        if (cur_masked) begin
          hdr_left = KEY_BYTES;
          ph = PH_KEY;
          return 1'b0;
        end
        return header_end(r);
      end
      PH_KEY: begin
        key      = {key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left != 4'd0) return 1'b0;
        return header_end(r);
      end
      default: begin
        // key byte order: first key byte sits in the top of the word
        kb      = cur_masked ? key[{~key_pos, 3'b000} +: 8] : 8'h00;
        d       = b ^ kb;
        key_pos = key_pos + 2'd1;
        left    = left - 64'd1;
        last_b  = (left == 64'd0);
        if (last_b) ph = PH_HDR;
        if (cur_op <= 4'd2) begin
          r = make_ev(EV_PAYLOAD, d, last_b, 16'h0000);
          return 1'b1;
        end
        if (cur_op == OPCODE_CLOSE) begin
          status   = {status[7:0], d};
          hdr_left = hdr_left + 4'd1;
          if (hdr_left >= 4'd2 || last_b) begin
            if (hdr_left == 4'd1) status = {status[7:0], 8'h00};
            stopped = 1'b1;
            r = make_ev(EV_CLOSE, 8'h00, 1'b0, status);
            return 1'b1;
          end
        end
        return 1'b0;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic typed,
                           input wsdf_result_t want);
    wsdf_result_t ev;
    bit           has;
    if (!calm && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent++;
    has = deframe_byte(b, ev);
    if (typed) pending_events = {pending_events, want};
    else if (has) pending_events = {pending_events, ev};
  endtask

  // enc: 0 seven-bit length, 1 sixteen-bit extension, 2 sixty-four-bit extension
  task automatic send_frame(input logic [3:0] op, input logic fin, input logic masked,
                            input int enc, input int len);
    logic [63:0] len64;
    len64 = 64'(len);
    push_byte({fin, 3'b000, op}, 1'b0, '0);
    case (enc)
      0: push_byte({masked, len64[6:0]}, 1'b0, '0);
      1: begin
        push_byte({masked, LEN_MAGIC_16}, 1'b0, '0);
        push_byte(len64[15:8], 1'b0, '0);
        push_byte(len64[7:0], 1'b0, '0);
      end
      default: begin
        push_byte({masked, LEN_MAGIC_64}, 1'b0, '0);
        for (int i = 7; i >= 0; i--) push_byte(len64[8*i +: 8], 1'b0, '0);
      end
    endcase
    if (masked) begin
      repeat (4) push_byte(8'($urandom), 1'b0, '0);
    end
    repeat (len) push_byte(8'($urandom), 1'b0, '0);
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    int           hold_left;
    wsdf_result_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_events.size() == 0) begin
          note_mismatch("unexpected transfer", out_tdata, 32'h0);
        end else begin
          want = pending_events.pop_front();
          if (out_tuser != want.kind)
            note_mismatch("event_kind", 32'(out_tuser), 32'(want.kind));
          if (out_tdata[7:0] != want.payload)
            note_mismatch("payload_byte", 32'(out_tdata[7:0]), 32'(want.payload));
          if (out_tdata[11:8] != want.opcode)
            note_mismatch("frame_opcode", 32'(out_tdata[11:8]), 32'(want.opcode));
          if (out_tdata[12] != want.fin)
            note_mismatch("frame_final", 32'(out_tdata[12]), 32'(want.fin));
          if (out_tdata[28:13] != want.close_code)
            note_mismatch("close_code", 32'(out_tdata[28:13]), 32'(want.close_code));
          if (out_tlast != want.last)
            note_mismatch("last_of_frame", 32'(out_tlast), 32'(want.last));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin
    bit         held;
    bit         paused;
    int         r;
    int         enc;
    int         len;
    logic [3:0] op;
    held   = 1'b0;
    paused = 1'b0;
    dir_rows = '{
      {8'h82, 1'b0, 32'h0},
      {8'h00, 1'b1, EV_EMPTY, 8'h00, 4'h2, 1'b1, 1'b1, 16'h0000},
      {8'h01, 1'b0, 32'h0},
      {8'h81, 1'b0, 32'h0},
      {8'hFF, 1'b0, 32'h0},
      {8'hFF, 1'b0, 32'h0},
      {8'hFF, 1'b0, 32'h0},
      {8'hFF, 1'b0, 32'h0},
      {8'h00, 1'b1, EV_PAYLOAD, 8'hFF, 4'h1, 1'b0, 1'b1, 16'h0000},
      {8'h89, 1'b0, 32'h0},
      {8'h01, 1'b0, 32'h0},
      {8'h5A, 1'b0, 32'h0},
      {8'h80, 1'b0, 32'h0},
      {8'hFE, 1'b0, 32'h0},
      {8'h00, 1'b0, 32'h0},
      {8'h01, 1'b0, 32'h0},
      {8'h12, 1'b0, 32'h0},
      {8'h34, 1'b0, 32'h0},
      {8'h56, 1'b0, 32'h0},
      {8'h78, 1'b0, 32'h0},
      {8'hFF, 1'b0, 32'h0},
      {8'h8A, 1'b0, 32'h0},
      {8'h00, 1'b0, 32'h0}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    while (sent < 1523) begin
      if (!held && sent > 400) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent > 800) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
      end
      calm = (sent > 1000 && sent < 1300);
      op = ($urandom_range(99) < 70) ? 4'($urandom_range(2))
                                      : (($urandom_range(1) != 0) ? OP_PING : OP_PONG);
      r = $urandom_range(99);
      if (r < 70) begin
        enc = 0;
        len = $urandom_range(20);
      end else if (r < 85) begin
        enc = 0;
        len = $urandom_range(125);
      end else if (r < 93) begin
        enc = 1;
        len = $urandom_range(300);
      end else begin
        enc = 2;
        len = $urandom_range(40);
      end
      send_frame(op, 1'($urandom), 1'($urandom), enc, len);
    end
    calm = 1'b0;

    // one terminating event per run, then bytes that must be dropped
    case ($urandom_range(5))
      0: begin
        op = 4'($urandom_range(3, 12));
        if (op > 4'd7) op = op + 4'd3;
        push_byte({1'($urandom), 3'b000, op}, 1'b0, '0);
      end
      1: push_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom_range(2))},
                   1'b0, '0);
      2: send_frame(OPCODE_CLOSE, 1'($urandom), 1'($urandom), 0, 0);
      3: send_frame(OPCODE_CLOSE, 1'($urandom), 1'($urandom), 0, 1);
      4: send_frame(OPCODE_CLOSE, 1'($urandom), 1'($urandom), 0, 2);
      default: send_frame(OPCODE_CLOSE, 1'($urandom), 1'($urandom), 0,
                          $urandom_range(3, 6));
    endcase
    repeat (12) push_byte(8'($urandom), 1'b0, '0);
    push_byte(8'h82, 1'b0, '0);
    push_byte(8'h00, 1'b0, '0);

    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
